>>> hw/rtl/eeg_packet_attention_parser_assert.svh
// Assertion macros used by the EEG attention packet parser checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef EEG_PACKET_ATTENTION_PARSER_ASSERT_SVH
`define EEG_PACKET_ATTENTION_PARSER_ASSERT_SVH

// Checked at every rising edge outside reset.
`define EPAP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define EPAP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/epap_pkg.sv
// Shared types and constants of the EEG attention packet parser.
// Depends on nothing; imported by the framer, the checker and the top level.
`timescale 1ns / 1ps
`default_nettype none

package epap_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] SYNC_BYTE = 8'hAA;

  localparam logic [ByteW-1:0] LENGTH_LIMIT_RESET = 8'd169;
  localparam logic [ByteW-1:0] VALUE_CODE_RESET   = 8'd4;
  localparam logic [ByteW-1:0] VALUE_MAX_RESET    = 8'd100;

  localparam int unsigned CfgIndexW = 2;

  localparam logic [CfgIndexW-1:0] CFG_LENGTH_LIMIT = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_VALUE_CODE   = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_VALUE_MAX    = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0] length_limit;
    logic [ByteW-1:0] value_code;
    logic [ByteW-1:0] value_max;
  } cfg_t;

  typedef struct packed {
    logic             emit;
    logic             checksum_ok;
    logic             value_found;
    logic [ByteW-1:0] attention_value;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/eeg_packet_attention_parser.sv
// Top level of the EEG attention packet parser: input register, frame tracker,
// result register and configuration registers. Depends on epap_pkg, epap_framer.
//
// Channel  Handshake            Payload
// in       in_valid / in_ready  rx_byte
// out      out_valid / out_ready checksum_ok, value_found, attention_value
// cfg      cfg_we               cfg_index, cfg_data
//
// One byte is taken per cycle when not stalled; a checksum beat loads the result.
// Only a checksum byte needs the result register, so other bytes keep flowing
// while a result waits; a checksum byte stalls the input until that result is taken.
// Reset is synchronous and returns the framing to the sync hunt, the configuration
// registers to their defaults and the input and result registers to empty.
`timescale 1ns / 1ps
`default_nettype none

module eeg_packet_attention_parser
  import epap_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [ByteW-1:0]     rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      checksum_ok,
  output logic                      value_found,
  output logic [ByteW-1:0]          attention_value,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [ByteW-1:0]     cfg_data
);

  cfg_t             cfg;
  logic             in_held;
  logic [ByteW-1:0] in_byte;
  logic             advance;
  result_t          result;

  assign advance  = in_held && (!result.emit || !out_valid || out_ready);
  assign in_ready = !in_held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.length_limit <= LENGTH_LIMIT_RESET;
      cfg.value_code   <= VALUE_CODE_RESET;
      cfg.value_max    <= VALUE_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LENGTH_LIMIT: cfg.length_limit <= cfg_data;
        CFG_VALUE_CODE:   cfg.value_code   <= cfg_data;
        CFG_VALUE_MAX:    cfg.value_max    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_ready) begin
      in_held <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_byte <= rx_byte;
    end
  end

  epap_framer u_framer (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .data   (in_byte),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && result.emit) begin
      checksum_ok     <= result.checksum_ok;
      value_found     <= result.value_found;
      attention_value <= result.attention_value;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/epap_framer.sv
// Frame tracker of the EEG attention packet parser: sync hunt, length check,
// payload sum and attention value scan. Depends on epap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module epap_framer
  import epap_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [ByteW-1:0] data,
  input  wire cfg_t             cfg,
  output result_t               result
);

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_LEN,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  phase_t           phase;
  logic [ByteW-1:0] frame_length;
  logic [ByteW-1:0] bytes_seen;
  logic [ByteW-1:0] running_sum;
  logic             expect_value;
  logic [ByteW-1:0] held_value;
  logic             held_valid;

  logic [ByteW-1:0] bytes_seen_next;
  logic             checksum_match;

  assign bytes_seen_next = bytes_seen + 8'd1;
  assign checksum_match  = (data == ~running_sum);

  always_comb begin
    result.emit            = (phase == PH_CHECK);
    result.checksum_ok     = checksum_match;
    result.value_found     = checksum_match && held_valid;
    result.attention_value = (checksum_match && held_valid) ? held_value : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC1;
      frame_length <= '0;
      bytes_seen   <= '0;
      running_sum  <= '0;
      expect_value <= 1'b0;
      held_value   <= '0;
      held_valid   <= 1'b0;
    end else if (step) begin
      case (phase)
        PH_SYNC1: begin
          phase <= (data == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
        end
        PH_SYNC2: begin
          phase <= (data == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
        end
        PH_LEN: begin
          if (data < cfg.length_limit) begin
            frame_length <= data;
            bytes_seen   <= '0;
            running_sum  <= '0;
            expect_value <= 1'b0;
            held_value   <= '0;
            held_valid   <= 1'b0;
            phase        <= (data == '0) ? PH_CHECK : PH_PAYLOAD;
          end else begin
            phase <= PH_SYNC1;
          end
        end
        PH_PAYLOAD: begin
          running_sum <= running_sum + data;
          bytes_seen  <= bytes_seen_next;
          if (expect_value) begin
            expect_value <= 1'b0;
            if (data <= cfg.value_max) begin
              held_value <= data;
              held_valid <= 1'b1;
            end
          end else if (data == cfg.value_code) begin
            expect_value <= 1'b1;
          end
          if (bytes_seen_next >= frame_length) begin
            phase <= PH_CHECK;
          end
        end
        PH_CHECK: begin
          expect_value <= 1'b0;
          phase        <= PH_SYNC1;
        end
        default: begin
          phase <= (data == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/epap_checker.sv
// Port-level checker of the EEG attention packet parser and its bind.
// Depends on epap_pkg and eeg_packet_attention_parser_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "eeg_packet_attention_parser_assert.svh"

module epap_checker
  import epap_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 checksum_ok,
  input wire logic                 value_found,
  input wire logic [ByteW-1:0]     attention_value
);

  logic [ByteW+1:0] out_word;

  assign out_word = {checksum_ok, value_found, attention_value};

  `EPAP_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "result valid after reset")
  `EPAP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word), "stalled result changed")
  `EPAP_ASSERT(a_found_needs_ok, out_valid && value_found |-> checksum_ok, "value found on a bad checksum")
  `EPAP_ASSERT(a_zero_when_none, out_valid && !value_found |-> attention_value == '0, "attention value nonzero without a value")
  `EPAP_ASSERT(a_ready_when_out_free, !out_valid || out_ready |-> in_ready, "input stalled with a free result register")

endmodule

bind eeg_packet_attention_parser epap_checker u_epap_checker (.*);

`default_nettype wire
